FILE: design/rswt_pkg.sv
// ----------------------------------------------------------------------------
// rswt_pkg: shared types and codes of the radio source window tracker
// Operation, status, state and reason codes; the command record that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package rswt_pkg;

    localparam logic [3:0] OP_CLEAR   = 4'd0;
    localparam logic [3:0] OP_START   = 4'd1;
    localparam logic [3:0] OP_TRANS   = 4'd2;
    localparam logic [3:0] OP_OBSERVE = 4'd3;
    localparam logic [3:0] OP_STOP    = 4'd4;
    localparam logic [3:0] OP_CANCEL  = 4'd5;
    localparam logic [3:0] OP_POP     = 4'd6;
    localparam logic [3:0] OP_DUTY    = 4'd7;
    localparam logic [3:0] OP_READ    = 4'd8;

    localparam logic [3:0] ST_STARTED    = 4'd0;
    localparam logic [3:0] ST_TRANSITION = 4'd1;
    localparam logic [3:0] ST_OBSERVED   = 4'd2;
    localparam logic [3:0] ST_DEQUEUED   = 4'd3;
    localparam logic [3:0] ST_STOPPED    = 4'd4;
    localparam logic [3:0] ST_CANCELLED  = 4'd5;
    localparam logic [3:0] ST_BAD_MASK   = 4'd6;
    localparam logic [3:0] ST_BAD_SOURCE = 4'd7;
    localparam logic [3:0] ST_BAD_REASON = 4'd8;
    localparam logic [3:0] ST_BAD_STATE  = 4'd9;
    localparam logic [3:0] ST_ORDER      = 4'd10;
    localparam logic [3:0] ST_SAME       = 4'd11;
    localparam logic [3:0] ST_FULL       = 4'd12;
    localparam logic [3:0] ST_EMPTY      = 4'd13;
    localparam logic [3:0] ST_DONE       = 4'd14;

    localparam logic [2:0] WS_SCHEDULED   = 3'd1;
    localparam logic [2:0] WS_ACTIVE      = 3'd2;
    localparam logic [2:0] WS_UNAVAILABLE = 3'd3;
    localparam logic [2:0] WS_FAULT       = 3'd4;
    localparam logic [2:0] WS_STOPPED     = 3'd5;

    localparam logic [2:0] RS_NONE        = 3'd0;
    localparam logic [2:0] RS_DUTY        = 3'd1;
    localparam logic [2:0] RS_UNAVAILABLE = 3'd2;
    localparam logic [2:0] RS_CONFLICT    = 3'd3;
    localparam logic [2:0] RS_FAULT       = 3'd4;

    localparam logic [1:0] RUN_IDLE      = 2'd0;
    localparam logic [1:0] RUN_RUNNING   = 2'd1;
    localparam logic [1:0] RUN_STOPPED   = 2'd2;
    localparam logic [1:0] RUN_CANCELLED = 2'd3;

    localparam logic [9:0] PERMILLE = 10'd1000;

    typedef struct packed {
        logic [3:0]  operation;
        logic [1:0]  source;
        logic [2:0]  new_state;
        logic [2:0]  reason;
        logic        accepted;
        logic [63:0] time_us;
        logic [3:0]  counter_id;
        logic [1:0]  mask;
    } rswt_cmd_t;

    localparam int CMD_BITS = $bits(rswt_cmd_t);

    typedef struct packed {
        logic [3:0]  status;
        logic        out_source;
        logic [2:0]  out_state;
        logic [2:0]  out_reason;
        logic [63:0] out_start_us;
        logic [63:0] out_end_us;
        logic [31:0] out_accepted;
        logic [31:0] out_dropped;
        logic [9:0]  duty_permille;
        logic [63:0] counter_value;
    } rswt_res_t;

    function automatic logic reason_fits(input logic [2:0] st, input logic [2:0] rs);
        logic ok;
        unique case (st)
            WS_SCHEDULED:   ok = (rs == RS_DUTY);
            WS_ACTIVE:      ok = (rs == RS_NONE);
            WS_UNAVAILABLE: ok = (rs == RS_UNAVAILABLE) || (rs == RS_CONFLICT);
            WS_FAULT:       ok = (rs == RS_FAULT);
            default:        ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

FILE: design/rswt_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rswt_cmd_fifo: two-entry command queue
// Decouples the accepting front end from the executing back end.
// ----------------------------------------------------------------------------
module rswt_cmd_fifo
    import rswt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  rswt_cmd_t in_cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output rswt_cmd_t out_cmd
);

    rswt_cmd_t  mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    wire push = in_valid && in_ready;
    wire pop  = out_valid && out_ready;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: design/rswt_divider.sv
// ----------------------------------------------------------------------------
// rswt_divider: bit-serial per-mille divider
// floor(a*1000/e) for a < e, restoring division one bit per cycle.
// ----------------------------------------------------------------------------
module rswt_divider
    import rswt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] act,
    input  logic [63:0] elapsed,
    output logic        done,
    output logic [9:0]  quotient
);

    // a*1000 < 1000*e, so the quotient fits 10 bits; since hi < e, feeding
    // the low 64 bits with remainder preloaded by the high word is exact.
    logic [73:0] prod_reg;
    logic [63:0] rem_reg, den_reg;
    logic [9:0]  q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic        mul_reg;

    logic [64:0] rem_sh;
    logic        take;

    assign rem_sh = {rem_reg, prod_reg[63 - cnt_reg[5:0]]};
    assign take   = rem_sh >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mul_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                prod_reg <= {10'd0, act} * {64'd0, PERMILLE};
                den_reg  <= elapsed;
                mul_reg  <= 1'b1;
            end else if (mul_reg) begin
                mul_reg  <= 1'b0;
                busy_reg <= 1'b1;
                rem_reg  <= {54'd0, prod_reg[73:64]};
                q_reg    <= '0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= take ? 64'(rem_sh - {1'b0, den_reg}) : rem_sh[63:0];
                q_reg   <= {q_reg[8:0], take};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/rswt_core.sv
// ----------------------------------------------------------------------------
// rswt_core: window tracker execution unit
// Holds all tracker state and the window queue; runs one command at a time.
// ----------------------------------------------------------------------------
module rswt_core
    import rswt_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16,
    parameter int COUNTER_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  rswt_cmd_t cmd,
    output logic      res_valid,
    input  logic      res_ready,
    output rswt_res_t res
);

    localparam int QW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_CLOSE = 4'b0100,
        S_WAIT  = 4'b1000
    } state_t;

    state_t state_reg;

    logic [1:0]  run_reg;
    logic [1:0]  sel_reg;
    logic [2:0]  sst_reg   [2];
    logic [2:0]  orsn_reg  [2];
    logic [63:0] ostart_reg[2];
    logic [31:0] oacc_reg  [2];
    logic [31:0] odrop_reg [2];
    logic [63:0] tis_reg   [8];
    logic [COUNTER_BITS-1:0] evt_reg[8];
    logic [63:0] sstart_reg, send_reg, latest_reg;
    logic [QW-1:0] head_reg;
    logic [FW-1:0] fill_reg, hw_reg;
    logic [COUNTER_BITS-1:0] ovf_reg;

    logic [6:0]   qtag_mem [WINDOW_DEPTH];
    logic [63:0]  qbeg_mem [WINDOW_DEPTH];
    logic [63:0]  qfin_mem [WINDOW_DEPTH];
    logic [63:0]  qcnt_mem [WINDOW_DEPTH];

    rswt_cmd_t c_reg;
    rswt_res_t res_reg;
    logic      res_valid_reg;
    logic      close_src_reg;    // source closed in S_CLOSE
    logic      close_more_reg;   // second source still to close
    logic      pop_pend_reg;
    logic [QW-1:0] pop_idx_reg;
    logic      div_pend_reg;

    // divider
    logic        div_start, div_done;
    logic [63:0] div_act, div_el;
    logic [9:0]  div_q;

    rswt_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .act(div_act), .elapsed(div_el), .done(div_done), .quotient(div_q)
    );

    assign cmd_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    wire        s_ok  = !c_reg.source[1];
    wire        s     = c_reg.source[0];
    wire [63:0] t     = c_reg.time_us;
    // tail = head + fill, wrapped once
    wire [QW:0]   tail_sum = {1'b0, head_reg} + (QW+1)'(fill_reg);
    wire [QW-1:0] tail = (tail_sum >= (QW+1)'(WINDOW_DEPTH))
                         ? QW'(tail_sum - (QW+1)'(WINDOW_DEPTH)) : tail_sum[QW-1:0];
    wire [1:0]  needed = {1'b0, sel_reg[0]} + {1'b0, sel_reg[1]};

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[64] ? '1 : sum[63:0];
    endfunction

    // duty evaluation terms
    logic        duty_zero;
    logic [63:0] duty_end, duty_act, duty_el;
    always_comb begin
        duty_end  = (run_reg == RUN_RUNNING) ? t : send_reg;
        duty_zero = !s_ok || !sel_reg[s] || (t < sstart_reg) || (run_reg == RUN_IDLE)
                 || ((run_reg != RUN_RUNNING) && (t < send_reg))
                 || (duty_end <= sstart_reg) || (duty_end < latest_reg);
        duty_act  = tis_reg[{s, 2'd1}];
        if (run_reg == RUN_RUNNING && sst_reg[s] == WS_ACTIVE && duty_end >= ostart_reg[s])
            duty_act = sat_add(duty_act, duty_end - ostart_reg[s]);
        duty_el = duty_end - sstart_reg;
    end
    assign div_act = duty_act;
    assign div_el  = duty_el;

    logic [63:0] rd_val;
    always_comb begin
        rd_val = '0;
        priority if (c_reg.counter_id < 4'd4)
            rd_val = tis_reg[{s, c_reg.counter_id[1:0]}];
        else if (c_reg.counter_id < 4'd8)
            rd_val = 64'(evt_reg[{s, c_reg.counter_id[1:0]}]);
        else if (c_reg.counter_id == 4'd8)
            rd_val = 64'(sst_reg[s]);
        else if (c_reg.counter_id == 4'd9)  rd_val = 64'(fill_reg);
        else if (c_reg.counter_id == 4'd10) rd_val = 64'(run_reg);
        else if (c_reg.counter_id == 4'd11) rd_val = sstart_reg;
        else if (c_reg.counter_id == 4'd12) rd_val = send_reg;
        else if (c_reg.counter_id == 4'd13) rd_val = latest_reg;
        else if (c_reg.counter_id == 4'd14) rd_val = 64'(hw_reg);
        else rd_val = 64'(ovf_reg);
    end

    logic div_go;
    assign div_start = div_go;

    always_ff @(posedge aclk) begin
        // queue pop read, registered
        if (pop_pend_reg) begin
            res_reg.out_source   <= qtag_mem[pop_idx_reg][6];
            res_reg.out_state    <= qtag_mem[pop_idx_reg][5:3];
            res_reg.out_reason   <= qtag_mem[pop_idx_reg][2:0];
            res_reg.out_start_us <= qbeg_mem[pop_idx_reg];
            res_reg.out_end_us   <= qfin_mem[pop_idx_reg];
            res_reg.out_accepted <= qcnt_mem[pop_idx_reg][31:0];
            res_reg.out_dropped  <= qcnt_mem[pop_idx_reg][63:32];
        end
        if (state_reg == S_CLOSE) begin
            qtag_mem[tail] <= {close_src_reg, sst_reg[close_src_reg], orsn_reg[close_src_reg]};
            qbeg_mem[tail] <= ostart_reg[close_src_reg];
            qfin_mem[tail] <= t;
            qcnt_mem[tail] <= {odrop_reg[close_src_reg], oacc_reg[close_src_reg]};
        end

        div_go <= 1'b0;
        if (!aresetn || (state_reg == S_EXEC && c_reg.operation == OP_CLEAR)
            || (state_reg == S_EXEC && c_reg.operation == OP_START
                && run_reg == RUN_IDLE && t != 0 && c_reg.mask != 0)) begin
            run_reg <= RUN_IDLE;
            sel_reg <= '0;
            for (int i = 0; i < 2; i++) begin
                sst_reg[i] <= '0; orsn_reg[i] <= '0; ostart_reg[i] <= '0;
                oacc_reg[i] <= '0; odrop_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++) begin
                tis_reg[i] <= '0; evt_reg[i] <= '0;
            end
            sstart_reg <= '0; send_reg <= '0; latest_reg <= '0;
            head_reg <= '0; fill_reg <= '0; hw_reg <= '0; ovf_reg <= '0;
        end
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            pop_pend_reg  <= 1'b0;
            div_pend_reg  <= 1'b0;
        end else begin
            pop_pend_reg <= 1'b0;
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        c_reg     <= cmd;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    res_reg.status        <= ST_DONE;
                    res_reg.out_source    <= '0;
                    res_reg.out_state     <= '0;
                    res_reg.out_reason    <= '0;
                    res_reg.out_start_us  <= '0;
                    res_reg.out_end_us    <= '0;
                    res_reg.out_accepted  <= '0;
                    res_reg.out_dropped   <= '0;
                    res_reg.duty_permille <= '0;
                    res_reg.counter_value <= '0;
                    state_reg <= S_WAIT;
                    unique case (c_reg.operation)
                        OP_CLEAR: ;
                        OP_START: begin
                            if (run_reg != RUN_IDLE) res_reg.status <= ST_BAD_STATE;
                            else if (t == 0 || c_reg.mask == 0) res_reg.status <= ST_BAD_MASK;
                            else begin
                                sstart_reg <= t; latest_reg <= t;
                                sel_reg <= c_reg.mask;
                                for (int i = 0; i < 2; i++) begin
                                    if (c_reg.mask[i]) begin
                                        sst_reg[i] <= WS_SCHEDULED;
                                        orsn_reg[i] <= RS_DUTY;
                                        ostart_reg[i] <= t;
                                    end
                                end
                                run_reg <= RUN_RUNNING;
                                res_reg.status <= ST_STARTED;
                            end
                        end
                        OP_TRANS: begin
                            priority if (!s_ok) res_reg.status <= ST_BAD_SOURCE;
                            else if (run_reg != RUN_RUNNING || !sel_reg[s]
                                     || c_reg.new_state < WS_SCHEDULED
                                     || c_reg.new_state > WS_FAULT)
                                res_reg.status <= ST_BAD_STATE;
                            else if (!reason_fits(c_reg.new_state, c_reg.reason))
                                res_reg.status <= ST_BAD_REASON;
                            else if (t < latest_reg || t < ostart_reg[s])
                                res_reg.status <= ST_ORDER;
                            else if (sst_reg[s] == c_reg.new_state)
                                res_reg.status <= ST_SAME;
                            else if (fill_reg >= FW'(WINDOW_DEPTH)) begin
                                if (ovf_reg != CMAX) ovf_reg <= ovf_reg + 1'b1;
                                res_reg.status <= ST_FULL;
                            end else begin
                                close_src_reg  <= s;
                                close_more_reg <= 1'b0;
                                state_reg      <= S_CLOSE;
                                res_reg.status <= ST_TRANSITION;
                            end
                        end
                        OP_OBSERVE: begin
                            priority if (!s_ok) res_reg.status <= ST_BAD_SOURCE;
                            else if (run_reg != RUN_RUNNING || !sel_reg[s]
                                     || sst_reg[s] != WS_ACTIVE)
                                res_reg.status <= ST_BAD_STATE;
                            else if (t < latest_reg || t < ostart_reg[s])
                                res_reg.status <= ST_ORDER;
                            else begin
                                if (c_reg.accepted) begin
                                    if (oacc_reg[s] != '1) oacc_reg[s] <= oacc_reg[s] + 1'b1;
                                    if (evt_reg[{s, 2'd2}] != CMAX)
                                        evt_reg[{s, 2'd2}] <= evt_reg[{s, 2'd2}] + 1'b1;
                                end else begin
                                    if (odrop_reg[s] != '1) odrop_reg[s] <= odrop_reg[s] + 1'b1;
                                    if (evt_reg[{s, 2'd3}] != CMAX)
                                        evt_reg[{s, 2'd3}] <= evt_reg[{s, 2'd3}] + 1'b1;
                                end
                                latest_reg <= t;
                                res_reg.status <= ST_OBSERVED;
                            end
                        end
                        OP_STOP, OP_CANCEL: begin
                            priority if (run_reg != RUN_RUNNING) res_reg.status <= ST_BAD_STATE;
                            else if (t < latest_reg) res_reg.status <= ST_ORDER;
                            else if ((FW+1)'(WINDOW_DEPTH) - (FW+1)'(fill_reg)
                                     < (FW+1)'(needed)) begin
                                if (ovf_reg != CMAX) ovf_reg <= ovf_reg + 1'b1;
                                res_reg.status <= ST_FULL;
                            end else begin
                                res_reg.status <= (c_reg.operation == OP_STOP)
                                                  ? ST_STOPPED : ST_CANCELLED;
                                if (sel_reg != 2'b00) begin
                                    close_src_reg  <= !sel_reg[0];
                                    close_more_reg <= (sel_reg == 2'b11);
                                    state_reg      <= S_CLOSE;
                                end else begin
                                    send_reg <= t; latest_reg <= t;
                                    run_reg <= (c_reg.operation == OP_STOP)
                                               ? RUN_STOPPED : RUN_CANCELLED;
                                end
                            end
                        end
                        OP_POP: begin
                            if (fill_reg == 0) res_reg.status <= ST_EMPTY;
                            else begin
                                pop_pend_reg <= 1'b1;
                                pop_idx_reg  <= head_reg;
                                head_reg <= (head_reg == QW'(WINDOW_DEPTH - 1))
                                            ? '0 : head_reg + 1'b1;
                                fill_reg <= fill_reg - 1'b1;
                                res_reg.status <= ST_DEQUEUED;
                            end
                        end
                        OP_DUTY: begin
                            if (!duty_zero) begin
                                if (duty_act >= duty_el) res_reg.duty_permille <= PERMILLE;
                                else begin
                                    div_go       <= 1'b1;
                                    div_pend_reg <= 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            if (c_reg.counter_id <= 4'd8 && !s_ok)
                                res_reg.status <= ST_BAD_SOURCE;
                            else res_reg.counter_value <= rd_val;
                        end
                        default: res_reg.status <= ST_BAD_STATE;
                    endcase
                end
                S_CLOSE: begin
                    fill_reg <= fill_reg + 1'b1;
                    if (fill_reg + 1'b1 > hw_reg) hw_reg <= fill_reg + 1'b1;
                    if (sst_reg[close_src_reg] >= WS_SCHEDULED
                        && sst_reg[close_src_reg] <= WS_FAULT)
                        tis_reg[{close_src_reg, 2'(sst_reg[close_src_reg] - 3'd1)}] <=
                            sat_add(tis_reg[{close_src_reg,
                                    2'(sst_reg[close_src_reg] - 3'd1)}],
                                    t - ostart_reg[close_src_reg]);
                    if (evt_reg[{close_src_reg, 2'd0}] != CMAX)
                        evt_reg[{close_src_reg, 2'd0}] <= evt_reg[{close_src_reg, 2'd0}] + 1'b1;
                    if (c_reg.operation == OP_TRANS) begin
                        sst_reg[close_src_reg]    <= c_reg.new_state;
                        orsn_reg[close_src_reg]   <= c_reg.reason;
                        ostart_reg[close_src_reg] <= t;
                        oacc_reg[close_src_reg]   <= '0;
                        odrop_reg[close_src_reg]  <= '0;
                        if (evt_reg[{close_src_reg, 2'd1}] != CMAX)
                            evt_reg[{close_src_reg, 2'd1}] <=
                                evt_reg[{close_src_reg, 2'd1}] + 1'b1;
                        latest_reg <= t;
                        state_reg  <= S_WAIT;
                    end else begin
                        sst_reg[close_src_reg] <= WS_STOPPED;
                        if (close_more_reg) begin
                            close_more_reg <= 1'b0;
                            close_src_reg  <= 1'b1;
                        end else begin
                            send_reg <= t; latest_reg <= t;
                            run_reg <= (c_reg.operation == OP_STOP)
                                       ? RUN_STOPPED : RUN_CANCELLED;
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (div_pend_reg) begin
                        if (div_done) begin
                            res_reg.duty_permille <= div_q;
                            div_pend_reg  <= 1'b0;
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end else if (!pop_pend_reg) begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: design/rswt_front.sv
// ----------------------------------------------------------------------------
// rswt_front: stream intake and configuration register
// Unpacks input transfers into commands tagged with the current source mask.
// ----------------------------------------------------------------------------
module rswt_front
    import rswt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [80:0] s_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        q_valid,
    input  logic        q_ready,
    output rswt_cmd_t   q_cmd
);

    logic [1:0] mask_reg;

    assign prdata   = (paddr == 2'd0) ? {30'd0, mask_reg} : 32'd0;
    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;

    always_comb begin
        q_cmd.operation  = s_tdata[3:0];
        q_cmd.source     = s_tdata[5:4];
        q_cmd.new_state  = s_tdata[8:6];
        q_cmd.reason     = s_tdata[11:9];
        q_cmd.accepted   = s_tdata[12];
        q_cmd.time_us    = s_tdata[76:13];
        q_cmd.counter_id = s_tdata[80:77];
        q_cmd.mask       = mask_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            mask_reg <= pwdata[1:0];
        end
    end

endmodule

FILE: design/radio_source_window_tracker.sv
// ----------------------------------------------------------------------------
// radio_source_window_tracker: window tracker for two radio sources
// Stream command in, one status/result transfer out per command.
// ----------------------------------------------------------------------------
// Each command runs to completion before the next starts; a duty query that
// needs the division waits for the bit-serial 64-step divider. A two-entry
// command queue lets the input keep accepting while a result waits. The
// window queue is a plain memory with fill count, so never-written entries
// are not cleared after reset.
// Config: register 0 (address 0) holds source_select_mask; it is sampled when
// a start command is queued.
// tdata bits [87:81] are padding and are ignored.
module radio_source_window_tracker
    import rswt_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16,
    parameter int COUNTER_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[3:0] source[5:4] new_state[8:6] reason[11:9] accepted[12]
    // time_us[76:13] counter_id[80:77]
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[3:0] out_source[4] out_state[7:5] out_reason[10:8]
    // out_start_us[74:11] out_end_us[138:75] out_accepted[170:139]
    // out_dropped[202:171] duty_permille[212:203] counter_value[276:213]
    output logic [279:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic      f_valid, f_ready, b_valid, b_ready;
    rswt_cmd_t f_cmd, b_cmd;
    rswt_res_t res;

    assign pready = 1'b1;

    rswt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata[80:0]),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata),
        .q_valid(f_valid), .q_ready(f_ready), .q_cmd(f_cmd)
    );

    rswt_cmd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
    );

    rswt_core #(
        .WINDOW_DEPTH(WINDOW_DEPTH), .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {3'd0, res.counter_value, res.duty_permille, res.out_dropped,
                      res.out_accepted, res.out_end_us, res.out_start_us,
                      res.out_reason, res.out_state, res.out_source, res.status};

endmodule
